// ===== rtl/bpq_pkg.sv =====
package bpq_pkg;

  localparam int unsigned KEY_W = 16;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned HELD_W = 9;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_PULL   = 1'b1
  } command_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED   = 3'd0,
    ST_OUT_OF_WIN = 3'd1,
    ST_FULL       = 3'd2,
    ST_PULLED     = 3'd3,
    ST_EMPTY      = 3'd4
  } status_e;

  typedef struct packed {
    logic              command;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] payload;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   payload_out;
    logic                queue_empty;
    logic [HELD_W-1:0]   held_count;
  } out_item_t;

endpackage

// ===== rtl/bpq_in_if.sv =====
interface bpq_in_if import bpq_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/bpq_out_if.sv =====
interface bpq_out_if import bpq_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/bpq_ram.sv =====
module bpq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bucket_priority_queue_unit.sv =====
// Bucket priority queue: one FIFO list per key in a window of NUM_BUCKETS keys that starts at
// base_key, over a shared store of CAPACITY elements. A transaction on in_i either inserts a
// payload at the tail of its key's bucket or pulls the head of the lowest non-empty bucket, and
// each produces exactly one result transaction on out_o. A rejected insert (key outside the
// window, store full) and a pull from an empty queue give their result straight from idle. An
// accepted insert first reads the tail and free-slot memories, then links the list. A pull scans
// from the minimum pointer, testing one bucket per cycle, until it finds a non-empty bucket; then
// the head, payload and link memories are read in turn. The unit takes one item at a time. The
// user must write base_key only while idle; the unit itself does not enforce this.
module bucket_priority_queue_unit import bpq_pkg::*; #(
  parameter int unsigned NUM_BUCKETS   = 64,
  parameter int unsigned CAPACITY      = 256,
  parameter int unsigned PAYLOAD_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [KEY_W-1:0] cfg_data_i,
  bpq_in_if.sink           in_i,
  bpq_out_if.source        out_o
);

  localparam int unsigned BW = $clog2(NUM_BUCKETS);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = PAYLOAD_WIDTH;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_PL1  = 3'd3;
  localparam logic [2:0] S_PL2  = 3'd4;

  logic [2:0]             state_q, state_d;
  logic [KEY_W-1:0]       base_q;
  logic [NUM_BUCKETS-1:0] nonempty_q, nonempty_d;
  logic [CW-1:0]          held_q, held_d;
  logic [CW-1:0]          rec_q, rec_d;
  logic [CW-1:0]          fresh_q, fresh_d;
  logic [BW-1:0]          min_q, min_d;
  logic [BW-1:0]          scan_q, scan_d;
  logic [BW-1:0]          bkt_q, bkt_d;
  logic [AW-1:0]          slot_q, slot_d;
  logic                   last_q, last_d;
  logic [PW-1:0]          pay_q, pay_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_q, out_d;

  logic                   out_free;
  logic                   accept;
  logic [KEY_W:0]         idx;
  logic                   in_win;
  logic                   do_result;
  status_e                res_status;
  logic [DATA_W-1:0]      res_payload;
  logic [AW-1:0]          new_slot;

  logic          head_we, head_re;
  logic [BW-1:0] head_waddr, head_raddr;
  logic [AW-1:0] head_wdata, head_rdata;
  logic          tail_we, tail_re;
  logic [BW-1:0] tail_waddr, tail_raddr;
  logic [AW-1:0] tail_wdata, tail_rdata;
  logic          link_we, link_re;
  logic [AW-1:0] link_waddr, link_raddr, link_wdata, link_rdata;
  logic          pl_we, pl_re;
  logic [AW-1:0] pl_waddr, pl_raddr;
  logic [PW-1:0] pl_wdata, pl_rdata;
  logic          stk_we, stk_re;
  logic [AW-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata;

  bpq_ram #(.WIDTH(AW), .DEPTH(NUM_BUCKETS)) u_head (
    .clk_i, .we_i(head_we), .waddr_i(head_waddr), .wdata_i(head_wdata),
    .re_i(head_re), .raddr_i(head_raddr), .rdata_o(head_rdata)
  );

  bpq_ram #(.WIDTH(AW), .DEPTH(NUM_BUCKETS)) u_tail (
    .clk_i, .we_i(tail_we), .waddr_i(tail_waddr), .wdata_i(tail_wdata),
    .re_i(tail_re), .raddr_i(tail_raddr), .rdata_o(tail_rdata)
  );

  bpq_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_link (
    .clk_i, .we_i(link_we), .waddr_i(link_waddr), .wdata_i(link_wdata),
    .re_i(link_re), .raddr_i(link_raddr), .rdata_o(link_rdata)
  );

  bpq_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_payload (
    .clk_i, .we_i(pl_we), .waddr_i(pl_waddr), .wdata_i(pl_wdata),
    .re_i(pl_re), .raddr_i(pl_raddr), .rdata_o(pl_rdata)
  );

  bpq_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_free (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .re_i(stk_re), .raddr_i(stk_raddr), .rdata_o(stk_rdata)
  );

  assign out_free    = !out_valid_q || out_o.ready;
  assign in_i.ready  = (state_q == S_IDLE) && out_free;
  assign accept      = in_i.valid && in_i.ready;
  assign idx         = {in_i.data.key[KEY_W-1], in_i.data.key} - {base_q[KEY_W-1], base_q};
  assign in_win      = !idx[KEY_W] && (idx < (KEY_W+1)'(NUM_BUCKETS));
  assign new_slot    = (rec_q != '0) ? stk_rdata : fresh_q[AW-1:0];
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_comb begin
    state_d     = state_q;
    nonempty_d  = nonempty_q;
    held_d      = held_q;
    rec_d       = rec_q;
    fresh_d     = fresh_q;
    min_d       = min_q;
    scan_d      = scan_q;
    bkt_d       = bkt_q;
    slot_d      = slot_q;
    last_d      = last_q;
    pay_d       = pay_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d       = out_q;
    do_result   = 1'b0;
    res_status  = ST_INSERTED;
    res_payload = '0;
    head_we = 1'b0; head_re = 1'b0; head_waddr = bkt_q; head_raddr = scan_q;
    head_wdata = new_slot;
    tail_we = 1'b0; tail_re = 1'b0; tail_waddr = bkt_q; tail_raddr = scan_q;
    tail_wdata = new_slot;
    link_we = 1'b0; link_re = 1'b0; link_waddr = tail_rdata; link_raddr = head_rdata;
    link_wdata = new_slot;
    pl_we = 1'b0; pl_re = 1'b0; pl_waddr = new_slot; pl_raddr = head_rdata;
    pl_wdata = pay_q;
    stk_we = 1'b0; stk_re = 1'b0; stk_waddr = rec_q[AW-1:0];
    stk_raddr = AW'(rec_q - CW'(1)); stk_wdata = slot_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_i.data.command == CMD_INSERT) begin
            if (!in_win) begin
              do_result  = 1'b1;
              res_status = ST_OUT_OF_WIN;
            end else if (held_q == CW'(CAPACITY)) begin
              do_result  = 1'b1;
              res_status = ST_FULL;
            end else begin
              bkt_d      = idx[BW-1:0];
              pay_d      = PW'(in_i.data.payload);
              tail_re    = 1'b1;
              tail_raddr = idx[BW-1:0];
              stk_re     = 1'b1;
              state_d    = S_INS;
            end
          end else if (held_q == '0) begin
            do_result  = 1'b1;
            res_status = ST_EMPTY;
          end else begin
            scan_d  = min_q;
            state_d = S_SCAN;
          end
        end
      end
      S_INS: begin
        if (out_free) begin
          if (rec_q != '0) begin
            rec_d = rec_q - CW'(1);
          end else begin
            fresh_d = fresh_q + CW'(1);
          end
          pl_we = 1'b1;
          if (nonempty_q[bkt_q]) begin
            link_we = 1'b1;
          end else begin
            head_we = 1'b1;
          end
          tail_we           = 1'b1;
          nonempty_d[bkt_q] = 1'b1;
          held_d            = held_q + CW'(1);
          if (bkt_q < min_q) begin
            min_d = bkt_q;
          end
          do_result  = 1'b1;
          res_status = ST_INSERTED;
          state_d    = S_IDLE;
        end
      end
      S_SCAN: begin
        if (nonempty_q[scan_q]) begin
          min_d   = scan_q;
          bkt_d   = scan_q;
          head_re = 1'b1;
          tail_re = 1'b1;
          state_d = S_PL1;
        end else if (scan_q == BW'(NUM_BUCKETS - 1)) begin
          scan_d = '0;
        end else begin
          scan_d = scan_q + BW'(1);
        end
      end
      S_PL1: begin
        slot_d  = head_rdata;
        last_d  = (head_rdata == tail_rdata);
        pl_re   = 1'b1;
        link_re = 1'b1;
        state_d = S_PL2;
      end
      S_PL2: begin
        if (out_free) begin
          if (last_q) begin
            nonempty_d[bkt_q] = 1'b0;
          end else begin
            head_we    = 1'b1;
            head_wdata = link_rdata;
          end
          stk_we      = 1'b1;
          rec_d       = rec_q + CW'(1);
          held_d      = held_q - CW'(1);
          do_result   = 1'b1;
          res_status  = ST_PULLED;
          res_payload = DATA_W'(pl_rdata);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (do_result) begin
      out_valid_d       = 1'b1;
      out_d.status      = res_status;
      out_d.payload_out = res_payload;
      out_d.queue_empty = (held_d == '0);
      out_d.held_count  = HELD_W'(held_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= '0;
      nonempty_q  <= '0;
      held_q      <= '0;
      rec_q       <= '0;
      fresh_q     <= '0;
      min_q       <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nonempty_q  <= nonempty_d;
      held_q      <= held_d;
      rec_q       <= rec_d;
      fresh_q     <= fresh_d;
      min_q       <= min_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        base_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bkt_q  <= bkt_d;
    slot_q <= slot_d;
    last_q <= last_d;
    pay_q  <= pay_d;
    out_q  <= out_d;
  end

  // Every issued slot is either held in a bucket or waiting on the free stack.
  a_slot_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q == held_q + rec_q)
    else $error("slot accounting broken");

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CW'(CAPACITY))
    else $error("held count above capacity");

  a_empty_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q == '0) |-> (nonempty_q == '0))
    else $error("bucket marked non-empty in an empty queue");

  a_pull_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.data.command == CMD_PULL && held_q != '0) |=> (state_q == S_SCAN))
    else $error("pull did not start the minimum scan");

endmodule
